[hdl/apeq_pkg.sv]
// apeq_pkg: shared types and constants for the aged priority event queue
// no dependencies
package apeq_pkg;
   localparam int SlotCount = 16;
   localparam int SlotBits = $clog2(SlotCount);
   localparam int CountBits = 5;
   localparam logic [6:0] TagPercent = 7'd100;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_CHOOSE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_PRELOAD = 2'd0,
      CSR_FILT_EN = 2'd1,
      CSR_FILT_PRI = 2'd2
   } csr_type;

   typedef struct packed {
      logic [15:0] priority_val;
      logic [15:0] max_age;
      logic [31:0] time_val;
      logic [15:0] order;
      logic keep;
      logic filterable;
      logic tag_flag;
      logic [31:0] payload;
   } slot_type;

   // age compare result from the shared unit
   typedef struct packed {
      logic expired;
      logic [31:0] age;
   } age_type;
endpackage

[hdl/apeq_age_unit.sv]
// apeq_age_unit: shared age and expiry evaluation for one slot per cycle
// depends on apeq_pkg
module apeq_age_unit (
   input  logic [31:0] ref_time,
   input  apeq_pkg::slot_type slot,
   output apeq_pkg::age_type result
);
   always_comb begin
      result.age = ref_time - slot.time_val;
      result.expired = (slot.max_age != 16'd0) && ({16'd0, slot.max_age} < result.age);
   end
endmodule

[hdl/aged_priority_event_queue_unit.sv]
// aged_priority_event_queue_unit: top level, sequencer and slot storage
// depends on apeq_pkg, apeq_age_unit
//
//  channel | ports                         | transfer
//  request | start, busy, req_*            | start & !busy
//  result  | rsp_strobe, rsp_*             | one cycle, rsp_strobe high
//  config  | csr_write, csr_index, csr_data| csr_write high
//
// add: up to 3 scans of 16 slots (free, expired, lower or equal priority); no scan
//   when rejected by the draw
// choose: no scan when empty, one scan with no winner, else scan plus older pass
// clear and unused codes skip all scans; the single age unit walks one slot per cycle
// reset clears valid bits and counters; slot fields are written before use
// results cannot be stalled; busy falls the cycle after the strobe, the next transfer
//   can come then
module aged_priority_event_queue_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_command,
   input  logic [31:0] req_now_tick,
   input  logic [15:0] req_event_priority,
   input  logic [15:0] req_event_max_age,
   input  logic req_keep_flag,
   input  logic req_filterable_flag,
   input  logic [6:0] req_accept_percent,
   input  logic [6:0] req_draw,
   input  logic [31:0] req_payload,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data,
   output logic rsp_strobe,
   output logic rsp_found,
   output logic [3:0] rsp_slot_index,
   output logic [31:0] rsp_win_payload,
   output logic rsp_tag_survives,
   output logic [4:0] rsp_pending_count
);
   localparam int SB = apeq_pkg::SlotBits;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_FREE = 8'b00000010,
      ST_EXP = 8'b00000100,
      ST_PRI = 8'b00001000,
      ST_PLACE = 8'b00010000,
      ST_SCAN = 8'b00100000,
      ST_OLDER = 8'b01000000,
      ST_DONE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] preload_ff;
   logic filt_en_ff;
   logic [15:0] filt_pri_ff;

   // slot storage; read one slot per cycle at the scan index
   apeq_pkg::slot_type slot_mem [apeq_pkg::SlotCount];
   logic [apeq_pkg::SlotCount-1:0] valid_ff, valid_in;
   logic [4:0] live_ff, live_in;
   logic [31:0] last_time_ff;
   logic [15:0] last_order_ff;
   logic surv_ff, surv_in;

   // latched request
   logic [1:0] cmd_ff;
   logic [31:0] now_ff;
   apeq_pkg::slot_type req_ff;

   logic [SB:0] idx_ff, idx_in;          // scan counter, one extra bit for the end
   logic [SB-1:0] sel_ff, sel_in;        // chosen slot
   logic have_ff, have_in;
   logic [15:0] best_pri_ff, best_pri_in;
   logic [31:0] best_age_ff, best_age_in;
   logic [15:0] best_sub_ff, best_sub_in;
   logic [31:0] win_time_ff, win_time_in;
   logic [15:0] win_ord_ff, win_ord_in;
   logic found_ff, found_in;
   logic [31:0] pay_ff, pay_in;
   logic wr_en;

   logic [SB-1:0] ci;
   apeq_pkg::slot_type cur;
   logic cur_valid, last_idx;
   logic [31:0] ref_time;
   apeq_pkg::age_type age_r;
   logic filtered;

   assign ci = idx_ff[SB-1:0];
   assign cur = slot_mem[ci];
   assign cur_valid = valid_ff[ci];
   assign last_idx = (idx_ff == (SB+1)'(apeq_pkg::SlotCount - 1));
   assign ref_time = (cmd_ff == apeq_pkg::CMD_CHOOSE) ? now_ff + preload_ff : now_ff;
   assign filtered = filt_en_ff && cur.filterable && (cur.priority_val < filt_pri_ff);

   apeq_age_unit u_age (.ref_time(ref_time), .slot(cur), .result(age_r));

   always_ff @(posedge clock) begin
      if (reset) begin
         preload_ff <= '0;
         filt_en_ff <= 1'b0;
         filt_pri_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            apeq_pkg::CSR_PRELOAD: preload_ff <= csr_data;
            apeq_pkg::CSR_FILT_EN: filt_en_ff <= csr_data[0];
            apeq_pkg::CSR_FILT_PRI: filt_pri_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      live_in = live_ff;
      surv_in = surv_ff;
      idx_in = idx_ff;
      sel_in = sel_ff;
      have_in = have_ff;
      best_pri_in = best_pri_ff;
      best_age_in = best_age_ff;
      best_sub_in = best_sub_ff;
      win_time_in = win_time_ff;
      win_ord_in = win_ord_ff;
      found_in = found_ff;
      pay_in = pay_ff;
      wr_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            found_in = 1'b0;
            pay_in = '0;
            sel_in = '0;
            have_in = 1'b0;
            best_pri_in = '0;
            best_age_in = '1;
            best_sub_in = '0;
            if (start) begin
               unique case (req_command)
                  apeq_pkg::CMD_ADD:
                     state_in = (req_draw <= req_accept_percent) ? ST_FREE : ST_DONE;
                  apeq_pkg::CMD_CHOOSE:
                     state_in = (live_ff != '0) ? ST_SCAN : ST_DONE;
                  apeq_pkg::CMD_CLEAR: begin
                     valid_in = '0;
                     live_in = '0;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FREE: begin
            if (!cur_valid) begin
               sel_in = ci;
               state_in = ST_PLACE;
            end else if (last_idx) begin
               idx_in = '0;
               state_in = ST_EXP;
            end else idx_in = idx_ff + 1'b1;
         end
         ST_EXP: begin
            if (age_r.expired) begin
               sel_in = ci;
               live_in = live_ff - 1'b1;
               state_in = ST_PLACE;
            end else if (last_idx) begin
               idx_in = '0;
               state_in = ST_PRI;
            end else idx_in = idx_ff + 1'b1;
         end
         ST_PRI: begin
            if (req_ff.priority_val >= cur.priority_val) begin
               sel_in = ci;
               live_in = live_ff - 1'b1;
               state_in = ST_PLACE;
            end else if (last_idx) state_in = ST_DONE;
            else idx_in = idx_ff + 1'b1;
         end
         ST_PLACE: begin
            wr_en = 1'b1;
            valid_in[sel_ff] = 1'b1;
            live_in = live_ff + 1'b1;
            found_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (cur_valid) begin
               if (age_r.expired || filtered) begin
                  valid_in[ci] = 1'b0;
                  live_in = live_ff - 1'b1;
               end else if (best_pri_ff < cur.priority_val) begin
                  have_in = 1'b1;
                  sel_in = ci;
                  best_pri_in = cur.priority_val;
                  best_age_in = age_r.age;
                  best_sub_in = cur.order;
                  win_time_in = cur.time_val;
                  win_ord_in = cur.order;
               end else if (cur.priority_val == best_pri_ff &&
                            (age_r.age < best_age_ff ||
                             (age_r.age == best_age_ff && best_sub_ff < cur.order))) begin
                  have_in = 1'b1;
                  sel_in = ci;
                  best_age_in = age_r.age;
                  best_sub_in = cur.order;
                  win_time_in = cur.time_val;
                  win_ord_in = cur.order;
               end
            end
            if (last_idx) begin
               idx_in = '0;
               if (have_in) begin
                  surv_in = 1'b0;
                  state_in = ST_OLDER;
               end else state_in = ST_DONE;
            end else idx_in = idx_ff + 1'b1;
         end
         ST_OLDER: begin
            if (ci != sel_ff && cur_valid) begin
               if (cur.time_val < win_time_ff ||
                   (cur.time_val == win_time_ff && cur.order < win_ord_ff)) begin
                  if (!cur.keep) begin
                     valid_in[ci] = 1'b0;
                     live_in = live_ff - 1'b1;
                  end
               end else if (cur.tag_flag) surv_in = 1'b1;
            end
            if (ci == sel_ff) pay_in = cur.payload;
            if (last_idx) begin
               valid_in[sel_ff] = 1'b0;
               live_in = live_in - 1'b1;
               found_in = 1'b1;
               state_in = ST_DONE;
            end else idx_in = idx_ff + 1'b1;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         live_ff <= '0;
         surv_ff <= 1'b0;
         last_time_ff <= '0;
         last_order_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         live_ff <= live_in;
         surv_ff <= surv_in;
         found_ff <= found_in;
         if (wr_en) begin
            last_time_ff <= now_ff;
            last_order_ff <= (now_ff == last_time_ff) ? last_order_ff + 1'b1 : 16'd0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sel_ff <= sel_in;
      have_ff <= have_in;
      best_pri_ff <= best_pri_in;
      best_age_ff <= best_age_in;
      best_sub_ff <= best_sub_in;
      win_time_ff <= win_time_in;
      win_ord_ff <= win_ord_in;
      pay_ff <= pay_in;
      if (state_ff == ST_IDLE && start) begin
         cmd_ff <= req_command;
         now_ff <= req_now_tick;
         req_ff.priority_val <= req_event_priority;
         req_ff.max_age <= req_event_max_age;
         req_ff.time_val <= req_now_tick;
         req_ff.order <= '0;
         req_ff.keep <= req_keep_flag;
         req_ff.filterable <= req_filterable_flag;
         req_ff.tag_flag <= (req_accept_percent == apeq_pkg::TagPercent);
         req_ff.payload <= req_payload;
      end
      if (wr_en) begin
         slot_mem[sel_ff] <= '{priority_val: req_ff.priority_val, max_age: req_ff.max_age,
            time_val: now_ff,
            order: (now_ff == last_time_ff) ? last_order_ff + 1'b1 : 16'd0,
            keep: req_ff.keep, filterable: req_ff.filterable, tag_flag: req_ff.tag_flag,
            payload: req_ff.payload};
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign rsp_found = found_ff;
   assign rsp_slot_index = found_ff ? 4'(sel_ff) : 4'd0;
   assign rsp_win_payload = pay_ff;
   assign rsp_tag_survives = surv_ff;
   assign rsp_pending_count = live_ff;
endmodule

[hdl/apeq_checker.sv]
// apeq_checker: port-level assertions for the event queue top level
// depends on aged_priority_event_queue_unit ports
module apeq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_found,
   input logic [3:0] rsp_slot_index,
   input logic [4:0] rsp_pending_count
);
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_pending_count <= 5'd16) else $error("count over capacity");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe while idle");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double strobe");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> rsp_slot_index == 4'd0) else $error("index without hit");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer not taken");
endmodule

bind aged_priority_event_queue_unit apeq_checker u_apeq_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_strobe(rsp_strobe),
   .rsp_found(rsp_found), .rsp_slot_index(rsp_slot_index),
   .rsp_pending_count(rsp_pending_count)
);
